// File: rtl/core/rtlp_pkg.sv
// Package for the rate to log pitch converter.
// Holds the scale and field constants, the magnitude and slope ROMs and
// the leading-one struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtlp_pkg;

  localparam int RateW  = 18;
  localparam int ProdW  = 32;
  localparam int PosW   = 5;
  localparam int IdxW   = 7;
  localparam int MagW   = 20;
  localparam int SlopeW = 7;
  localparam int FracW  = 7;
  localparam int TermW  = IdxW + SlopeW;
  localparam int ExpW   = ProdW - 20;

  localparam logic [13:0] SCALE_K   = 14'd11185;
  localparam logic [ExpW-1:0] EXP_BIAS = ExpW'(15);
  localparam int IdxShift  = 24;
  localparam int FracShift = 17;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] pos;
  } lead_t;

  localparam logic [MagW-1:0] MAG_ROM [0:127] = '{
    20'h00000, 20'h02dfc, 20'h05b9e, 20'h088e6, 20'h0b5d6, 20'h0e26f, 20'h10eb3, 20'h13aa2,
    20'h1663f, 20'h1918a, 20'h1bc84, 20'h1e72e, 20'h2118b, 20'h23b9a, 20'h2655d, 20'h28ed5,
    20'h2b803, 20'h2e0e8, 20'h30985, 20'h331db, 20'h359eb, 20'h381b6, 20'h3a93d, 20'h3d081,
    20'h3f782, 20'h41e42, 20'h444c1, 20'h46b01, 20'h49101, 20'h4b6c4, 20'h4dc49, 20'h50191,
    20'h5269e, 20'h54b6f, 20'h57006, 20'h59463, 20'h5b888, 20'h5dc74, 20'h60029, 20'h623a7,
    20'h646ee, 20'h66a00, 20'h68cdd, 20'h6af86, 20'h6d1fa, 20'h6f43c, 20'h7164b, 20'h73829,
    20'h759d4, 20'h77b4f, 20'h79c9a, 20'h7bdb5, 20'h7dea1, 20'h7ff5e, 20'h81fed, 20'h8404e,
    20'h86082, 20'h88089, 20'h8a064, 20'h8c014, 20'h8df98, 20'h8fef1, 20'h91e20, 20'h93d26,
    20'h95c01, 20'h97ab4, 20'h9993e, 20'h9b79f, 20'h9d5d9, 20'h9f3ec, 20'ha11d8, 20'ha2f9d,
    20'ha4d3c, 20'ha6ab5, 20'ha8808, 20'haa537, 20'hac241, 20'hadf26, 20'hafbe7, 20'hb1885,
    20'hb3500, 20'hb5157, 20'hb6d8c, 20'hb899f, 20'hba58f, 20'hbc15e, 20'hbdd0c, 20'hbf899,
    20'hc1404, 20'hc2f50, 20'hc4a7b, 20'hc6587, 20'hc8073, 20'hc9b3f, 20'hcb5ed, 20'hcd07c,
    20'hceaec, 20'hd053f, 20'hd1f73, 20'hd398a, 20'hd5384, 20'hd6d60, 20'hd8720, 20'hda0c3,
    20'hdba4a, 20'hdd3b4, 20'hded03, 20'he0636, 20'he1f4e, 20'he384a, 20'he512c, 20'he69f3,
    20'he829f, 20'he9b31, 20'heb3a9, 20'hecc08, 20'hee44c, 20'hefc78, 20'hf148a, 20'hf2c83,
    20'hf4463, 20'hf5c2a, 20'hf73da, 20'hf8b71, 20'hfa2f0, 20'hfba57, 20'hfd1a7, 20'hfe8df
  };

  localparam logic [SlopeW-1:0] SLOPE_ROM [0:127] = '{
    7'h5c, 7'h5c, 7'h5b, 7'h5a, 7'h5a, 7'h59, 7'h58, 7'h58,
    7'h57, 7'h56, 7'h56, 7'h55, 7'h55, 7'h54, 7'h53, 7'h53,
    7'h52, 7'h52, 7'h51, 7'h51, 7'h50, 7'h50, 7'h4f, 7'h4f,
    7'h4e, 7'h4d, 7'h4d, 7'h4d, 7'h4c, 7'h4c, 7'h4b, 7'h4b,
    7'h4a, 7'h4a, 7'h49, 7'h49, 7'h48, 7'h48, 7'h47, 7'h47,
    7'h47, 7'h46, 7'h46, 7'h45, 7'h45, 7'h45, 7'h44, 7'h44,
    7'h43, 7'h43, 7'h43, 7'h42, 7'h42, 7'h42, 7'h41, 7'h41,
    7'h41, 7'h40, 7'h40, 7'h40, 7'h3f, 7'h3f, 7'h3f, 7'h3e,
    7'h3e, 7'h3e, 7'h3d, 7'h3d, 7'h3d, 7'h3c, 7'h3c, 7'h3c,
    7'h3b, 7'h3b, 7'h3b, 7'h3b, 7'h3a, 7'h3a, 7'h3a, 7'h39,
    7'h39, 7'h39, 7'h39, 7'h38, 7'h38, 7'h38, 7'h38, 7'h37,
    7'h37, 7'h37, 7'h37, 7'h36, 7'h36, 7'h36, 7'h36, 7'h35,
    7'h35, 7'h35, 7'h35, 7'h34, 7'h34, 7'h34, 7'h34, 7'h34,
    7'h33, 7'h33, 7'h33, 7'h33, 7'h32, 7'h32, 7'h32, 7'h32,
    7'h32, 7'h31, 7'h31, 7'h31, 7'h31, 7'h31, 7'h30, 7'h30,
    7'h30, 7'h30, 7'h30, 7'h2f, 7'h2f, 7'h2f, 7'h2f, 7'h2f
  };

endpackage

`default_nettype wire

// File: rtl/core/rtlp_lead.sv
// Leading-one encoder for the scaled rate product.
// Searches bits 31 down to 1; uses rtlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtlp_lead
  import rtlp_pkg::*;
(
  input  wire logic [ProdW-1:0] prod,
  output lead_t                 lead
);

  always_comb begin
    lead = '0;
    // Ascending scan: the highest set bit wins. Bit 0 is ignored on purpose.
    for (int i = 1; i < ProdW; i++) begin
      if (prod[i]) begin
        lead.found = 1'b1;
        lead.pos   = PosW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rate_to_log_pitch.sv
// Rate to log pitch converter: five-stage pipeline (scale multiply,
// leading-one search, normalize shift, ROM lookup with slope multiply, sum).
// Throughput is one transaction per cycle while pitch_stall is low; under a
// stall a full stage waits until the stage after it is empty or moving, so
// bubbles close up.
// rst clears only the stage valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module rate_to_log_pitch
  import rtlp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rate_valid,
  output logic                  rate_stall,
  input  wire logic [RateW-1:0] rate,
  output logic                  pitch_valid,
  input  wire logic             pitch_stall,
  output logic [ProdW-1:0]      pitch
);

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [ProdW-1:0]  s1_prod;
  logic [ProdW-1:0]  s2_prod;
  lead_t             s2_lead;
  lead_t             lead;
  logic              s3_found;
  logic [ExpW-1:0]   s3_exp;
  logic [IdxW-1:0]   s3_idx;
  logic [FracW-1:0]  s3_frac;
  logic              s4_found;
  logic [ExpW-1:0]   s4_exp;
  logic [MagW-1:0]   s4_mag;
  logic [TermW-1:0]  s4_term;
  logic [ProdW-1:0]  norm;

  // Each stage loads when it is empty or the next stage moves on.
  assign rdy5 = !v5 || !pitch_stall;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rate_stall  = !rdy1;
  assign pitch_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= rate_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  rtlp_lead u_lead (
    .prod (s1_prod),
    .lead (lead)
  );

  assign norm = s2_prod << (PosW'(ProdW - 1) - s2_lead.pos);

  always_ff @(posedge clk) begin
    if (rdy1 && rate_valid) begin
      s1_prod <= ProdW'(rate) * ProdW'(SCALE_K);
    end
    if (rdy2 && v1) begin
      s2_prod <= s1_prod;
      s2_lead <= lead;
    end
    if (rdy3 && v2) begin
      s3_found <= s2_lead.found;
      s3_exp   <= ExpW'(s2_lead.pos) - EXP_BIAS;
      s3_idx   <= norm[IdxShift +: IdxW];
      s3_frac  <= norm[FracShift +: FracW];
    end
    if (rdy4 && v3) begin
      s4_found <= s3_found;
      s4_exp   <= s3_exp;
      s4_mag   <= MAG_ROM[s3_idx];
      s4_term  <= TermW'(s3_frac) * TermW'(SLOPE_ROM[s3_idx]);
    end
    if (rdy5 && v4) begin
      // A product with no set bit above bit zero gives a zero pitch.
      pitch <= s4_found ? ({s4_exp, 20'd0} + ProdW'(s4_mag) + ProdW'(s4_term))
                        : '0;
    end
  end

  a_lead_is_top: assert property (@(posedge clk) disable iff (rst)
    v2 && s2_lead.found |-> (s2_prod >> s2_lead.pos) == ProdW'(1))
    else $error("leading-one position does not match the stored product");

  a_found_flag: assert property (@(posedge clk) disable iff (rst)
    v2 |-> s2_lead.found == (s2_prod[ProdW-1:1] != '0))
    else $error("leading-one found flag disagrees with the product");

  a_hold_under_stall: assert property (@(posedge clk) disable iff (rst)
    v5 && pitch_stall && v4 |=> v4 && $stable(s4_mag) && $stable(s4_term))
    else $error("stage four changed while the output was stalled");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Testbench for rate_to_log_pitch: drives sample rates and checks every pitch word
// against a predictor with its own copy of the log2 magnitude and slope tables.
// Depends on rtlp_pkg for the port widths.
`timescale 1ns / 1ps

module testbench;
  import rtlp_pkg::RateW;
  import rtlp_pkg::ProdW;

  localparam logic [ProdW-1:0] RATE_SCALE = 32'd11185;
  localparam int               EXP_BIAS   = 15;
  localparam int               EXP_SHIFT  = 20;
  localparam int               DRAIN_WAIT = 10;
  localparam logic [RateW-1:0] RATE_MAX   = '1;

  localparam logic [19:0] LOG_MAG [128] = '{
    20'h00000, 20'h02dfc, 20'h05b9e, 20'h088e6, 20'h0b5d6, 20'h0e26f, 20'h10eb3, 20'h13aa2,
    20'h1663f, 20'h1918a, 20'h1bc84, 20'h1e72e, 20'h2118b, 20'h23b9a, 20'h2655d, 20'h28ed5,
    20'h2b803, 20'h2e0e8, 20'h30985, 20'h331db, 20'h359eb, 20'h381b6, 20'h3a93d, 20'h3d081,
    20'h3f782, 20'h41e42, 20'h444c1, 20'h46b01, 20'h49101, 20'h4b6c4, 20'h4dc49, 20'h50191,
    20'h5269e, 20'h54b6f, 20'h57006, 20'h59463, 20'h5b888, 20'h5dc74, 20'h60029, 20'h623a7,
    20'h646ee, 20'h66a00, 20'h68cdd, 20'h6af86, 20'h6d1fa, 20'h6f43c, 20'h7164b, 20'h73829,
    20'h759d4, 20'h77b4f, 20'h79c9a, 20'h7bdb5, 20'h7dea1, 20'h7ff5e, 20'h81fed, 20'h8404e,
    20'h86082, 20'h88089, 20'h8a064, 20'h8c014, 20'h8df98, 20'h8fef1, 20'h91e20, 20'h93d26,
    20'h95c01, 20'h97ab4, 20'h9993e, 20'h9b79f, 20'h9d5d9, 20'h9f3ec, 20'ha11d8, 20'ha2f9d,
    20'ha4d3c, 20'ha6ab5, 20'ha8808, 20'haa537, 20'hac241, 20'hadf26, 20'hafbe7, 20'hb1885,
    20'hb3500, 20'hb5157, 20'hb6d8c, 20'hb899f, 20'hba58f, 20'hbc15e, 20'hbdd0c, 20'hbf899,
    20'hc1404, 20'hc2f50, 20'hc4a7b, 20'hc6587, 20'hc8073, 20'hc9b3f, 20'hcb5ed, 20'hcd07c,
    20'hceaec, 20'hd053f, 20'hd1f73, 20'hd398a, 20'hd5384, 20'hd6d60, 20'hd8720, 20'hda0c3,
    20'hdba4a, 20'hdd3b4, 20'hded03, 20'he0636, 20'he1f4e, 20'he384a, 20'he512c, 20'he69f3,
    20'he829f, 20'he9b31, 20'heb3a9, 20'hecc08, 20'hee44c, 20'hefc78, 20'hf148a, 20'hf2c83,
    20'hf4463, 20'hf5c2a, 20'hf73da, 20'hf8b71, 20'hfa2f0, 20'hfba57, 20'hfd1a7, 20'hfe8df
  };

  localparam logic [6:0] LOG_SLOPE [128] = '{
    7'h5c, 7'h5c, 7'h5b, 7'h5a, 7'h5a, 7'h59, 7'h58, 7'h58,
    7'h57, 7'h56, 7'h56, 7'h55, 7'h55, 7'h54, 7'h53, 7'h53,
    7'h52, 7'h52, 7'h51, 7'h51, 7'h50, 7'h50, 7'h4f, 7'h4f,
    7'h4e, 7'h4d, 7'h4d, 7'h4d, 7'h4c, 7'h4c, 7'h4b, 7'h4b,
    7'h4a, 7'h4a, 7'h49, 7'h49, 7'h48, 7'h48, 7'h47, 7'h47,
    7'h47, 7'h46, 7'h46, 7'h45, 7'h45, 7'h45, 7'h44, 7'h44,
    7'h43, 7'h43, 7'h43, 7'h42, 7'h42, 7'h42, 7'h41, 7'h41,
    7'h41, 7'h40, 7'h40, 7'h40, 7'h3f, 7'h3f, 7'h3f, 7'h3e,
    7'h3e, 7'h3e, 7'h3d, 7'h3d, 7'h3d, 7'h3c, 7'h3c, 7'h3c,
    7'h3b, 7'h3b, 7'h3b, 7'h3b, 7'h3a, 7'h3a, 7'h3a, 7'h39,
    7'h39, 7'h39, 7'h39, 7'h38, 7'h38, 7'h38, 7'h38, 7'h37,
    7'h37, 7'h37, 7'h37, 7'h36, 7'h36, 7'h36, 7'h36, 7'h35,
    7'h35, 7'h35, 7'h35, 7'h34, 7'h34, 7'h34, 7'h34, 7'h34,
    7'h33, 7'h33, 7'h33, 7'h33, 7'h32, 7'h32, 7'h32, 7'h32,
    7'h32, 7'h31, 7'h31, 7'h31, 7'h31, 7'h31, 7'h30, 7'h30,
    7'h30, 7'h30, 7'h30, 7'h2f, 7'h2f, 7'h2f, 7'h2f, 7'h2f
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             rate_valid = 1'b0;
  logic             rate_stall;
  logic [RateW-1:0] rate = '0;
  logic             pitch_valid;
  logic             pitch_stall = 1'b0;
  logic [ProdW-1:0] pitch;

  logic [ProdW-1:0] expected_pitch [$];
  int errors = 0;
  int rates_accepted = 0;
  int pitches_checked = 0;
  int zero_rates = 0;
  int input_stall_cycles = 0;

  // Idling controls shared between the test tasks and the stall generator.
  bit src_idle_en = 1'b0;
  bit sink_idle_en = 1'b0;
  int hold_request = 0;
  int hold_left = 0;
  int burst_left = 0;

  rate_to_log_pitch u_dut (
    .clk        (clk),
    .rst        (rst),
    .rate_valid (rate_valid),
    .rate_stall (rate_stall),
    .rate       (rate),
    .pitch_valid(pitch_valid),
    .pitch_stall(pitch_stall),
    .pitch      (pitch)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  // Pitch = exponent term + table magnitude + fraction * table slope, all modulo 2^32.
  function automatic logic [ProdW-1:0] log_pitch_of(input logic [RateW-1:0] r);
    logic [ProdW-1:0] scaled;
    logic [ProdW-1:0] norm;
    logic [ProdW-1:0] exp_term;
    logic [6:0]       idx;
    logic [6:0]       frac;
    int               lead;
    scaled = ProdW'(r) * RATE_SCALE;
    lead = 0;
    for (int b = 1; b < ProdW; b++) begin
      if (scaled[b]) lead = b;
    end
    if (r == '0 || lead == 0) return '0;
    norm = scaled << (31 - lead);
    idx = norm[30:24];
    frac = norm[23:17];
    // Below the bias the exponent term goes negative and wraps.
    exp_term = ProdW'(lead - EXP_BIAS) << EXP_SHIFT;
    return exp_term + ProdW'(LOG_MAG[idx]) + ProdW'(frac) * ProdW'(LOG_SLOPE[idx]);
  endfunction

  function automatic logic [RateW-1:0] random_rate();
    int k;
    case ($urandom_range(0, 9))
      0: return RateW'($urandom_range(0, 63));
      1: begin
        k = $urandom_range(0, RateW - 1);
        return RateW'((1 << k) + $urandom_range(0, 2) - 1);
      end
      2: begin
        case ($urandom_range(0, 5))
          0: return RateW'(8000);
          1: return RateW'(11025);
          2: return RateW'(22050);
          3: return RateW'(44100);
          4: return RateW'(48000);
          default: return RateW'(96000);
        endcase
      end
      default: return RateW'($urandom_range(0, 2 ** RateW - 1));
    endcase
  endfunction

  // Both transactions are seen here, so an expectation is always queued before its result.
  always @(posedge clk) begin : pitch_check
    logic [ProdW-1:0] want;
    if (!rst) begin
      if (rate_valid && rate_stall) input_stall_cycles++;
      if (rate_valid && !rate_stall) begin
        expected_pitch.push_back(log_pitch_of(rate));
        rates_accepted++;
        if (rate == '0) zero_rates++;
      end
      if (pitch_valid === 1'b1 && !pitch_stall) begin
        if (expected_pitch.size() == 0) begin
          $error("pitch: unexpected result, expected none, actual %h", pitch);
          errors++;
        end else begin
          want = expected_pitch.pop_front();
          if (pitch !== want) begin
            $error("pitch mismatch: expected %h, actual %h", want, pitch);
            errors++;
          end
          pitches_checked++;
        end
      end
    end
  end

  // Output stall generator: long hold-offs on request, otherwise random bursts when sink_idle_en is set.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      pitch_stall <= 1'b1;
      hold_left--;
    end else if (!sink_idle_en) begin
      pitch_stall <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      pitch_stall <= ($urandom_range(0, 2) == 0);
      burst_left = $urandom_range(0, 15);
    end
  end

  task automatic send_rate(input logic [RateW-1:0] r);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk) rate_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rate_valid <= 1'b1;
    rate <= r;
    @(posedge clk);
    while (rate_stall) @(posedge clk);
  endtask

  task automatic wait_for_pitches();
    @(negedge clk) rate_valid <= 1'b0;
    while (expected_pitch.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_rates();
    logic [RateW-1:0] rates [] = '{
      0, 1, 2, 3, 4, 7, 8000, 11025, 22050, 32000, 44100, 48000,
      88200, 96000, 176400, 192000, 65535, 65536, 131071, 131072,
      RATE_MAX - 1, RATE_MAX, 18'h2aaaa, 18'h15555
    };
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    foreach (rates[i]) send_rate(rates[i]);
    wait_for_pitches();
  endtask

  task automatic test_random_rates(input int count);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    repeat (count) send_rate(random_rate());
    wait_for_pitches();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall its input.
  task automatic test_output_backpressure();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    hold_request = 150;
    repeat (60) send_rate(random_rate());
    wait_for_pitches();
  endtask

  task automatic test_drain_pause();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    repeat (3) begin
      repeat (25) send_rate(random_rate());
      wait_for_pitches();
    end
  endtask

  task automatic test_streaming(input int count);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (count) send_rate(random_rate());
    wait_for_pitches();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_directed_rates();
    test_random_rates(1200);
    test_output_backpressure();
    test_drain_pause();
    test_streaming(500);

    // Catch any stray result after the last expected one.
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d rates (%0d of them zero); checked %0d pitch words.",
             rates_accepted, zero_rates, pitches_checked);
    $display("Input was held off for %0d cycles by output backpressure.",
             input_stall_cycles);
    if (errors == 0 && expected_pitch.size() == 0) begin
      $display("testbench passed");
    end else begin
      if (expected_pitch.size() != 0)
        $error("pitch: %0d results never arrived", expected_pitch.size());
      $display("testbench failed");
    end
    $finish;
  end

endmodule
